// ===== src/bitmap_block_allocator_macros.svh =====
// Assertion macros for the bitmap block allocator.
// Used by the RTL files that carry concurrent checks; no other dependencies.
`ifndef BITMAP_BLOCK_ALLOCATOR_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define BBA_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication check failed");

// next-cycle implication
`define BBA_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication check failed");

`endif

// ===== src/bba_pkg.sv =====
// Package for the bitmap block allocator: sizes, codes, state type,
// memory access struct and bit-search helpers. No dependencies.
package bba_pkg;

   localparam int MAX_BLOCKS  = 4096;
   localparam int WORD_BITS   = 64;
   localparam int MAP_WORDS   = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
   localparam int BIT_IDX_W   = $clog2(WORD_BITS);
   localparam int WORD_IDX_W  = $clog2(MAP_WORDS);
   localparam int BLK_W       = 12;
   localparam int CNT_W       = 13;
   localparam int WORD_CNT_W  = CNT_W - BIT_IDX_W;
   localparam int TOTAL_RESET = 4096;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;

   typedef logic [WORD_BITS-1:0]  word_type;
   typedef logic [WORD_IDX_W-1:0] word_idx_type;
   typedef logic [BIT_IDX_W-1:0]  bit_idx_type;

   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   localparam logic [1:0] STAT_OK     = 2'd0;
   localparam logic [1:0] STAT_FULL   = 2'd1;
   localparam logic [1:0] STAT_DOUBLE = 2'd2;
   localparam logic [1:0] STAT_RANGE  = 2'd3;

   localparam logic REG_TOTAL_BLOCKS = 1'b0;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ALLOC,
      ST_FREE_CHK,
      ST_DELIVER
   } state_type;

   typedef struct packed {
      word_idx_type rd_addr;
      logic         wr_en;
      word_idx_type wr_addr;
      word_type     wr_data;
   } ram_req_type;

   function automatic bit_idx_type first_one(input word_type bits);
      bit_idx_type idx;
      idx = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (bits[i]) begin
            idx = bit_idx_type'(i);
         end
      end
      return idx;
   endfunction

   function automatic word_type word_mask(input word_idx_type w,
                                          input logic [CNT_W-1:0] n);
      logic [WORD_CNT_W-1:0] full;
      bit_idx_type           rem;
      word_type              m;
      full = n[CNT_W-1:BIT_IDX_W];
      rem  = n[BIT_IDX_W-1:0];
      if (WORD_CNT_W'(w) < full) begin
         m = '1;
      end else if (WORD_CNT_W'(w) == full) begin
         m = (word_type'(1) << rem) - word_type'(1);
      end else begin
         m = '0;
      end
      return m;
   endfunction

endpackage

// ===== src/bba_map_ram.sv =====
// Free-map memory: one word per group of blocks, registered read.
// Per-word valid bits make unwritten words read as all free. Uses bba_pkg.
module bba_map_ram
   import bba_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  ram_req_type ram_req,
   output word_type    rd_data
);

   word_type             map_mem [MAP_WORDS];
   word_type             rd_q_ff;
   logic [MAP_WORDS-1:0] vld_ff;
   logic                 rd_vld_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         map_mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
      rd_q_ff <= map_mem[ram_req.rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (ram_req.wr_en) begin
            vld_ff[ram_req.wr_addr] <= 1'b1;
         end
         rd_vld_ff <= vld_ff[ram_req.rd_addr];
      end
   end

   assign rd_data = rd_vld_ff ? rd_q_ff : '0;

endmodule

// ===== src/bba_csr.sv =====
// Configuration register file: block count register on an APB-style port.
// Uses bba_pkg.
module bba_csr
   import bba_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [CNT_W-1:0]      total_blocks
);

   logic [CNT_W-1:0] total_ff;
   logic [CNT_W-1:0] total_in;
   logic             wr_hit;

   assign wr_hit = csr_psel && csr_penable && csr_pwrite &&
                   (csr_paddr[CSR_ADDR_W-1] == REG_TOTAL_BLOCKS);

   always_comb begin
      total_in = total_ff;
      if (wr_hit) begin
         total_in = csr_pwdata[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= CNT_W'(TOTAL_RESET);
      end else begin
         total_ff <= total_in;
      end
   end

   always_comb begin
      unique case (csr_paddr[CSR_ADDR_W-1])
         REG_TOTAL_BLOCKS: csr_prdata = CSR_DATA_W'(total_ff);
         default:          csr_prdata = '0;
      endcase
   end

   assign csr_pready   = 1'b1;
   assign total_blocks = total_ff;

endmodule

// ===== src/bba_ctrl.sv =====
// Request sequencer: first-fit word scan, free check, read-modify-write of
// the free map, and the result register. Uses bba_pkg and the macros header.
`include "bitmap_block_allocator_macros.svh"
module bba_ctrl
   import bba_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [CNT_W-1:0] total_blocks,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_action,
   input  logic [BLK_W-1:0] req_block_no,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [BLK_W-1:0] rsp_result_block,
   output logic [1:0]       rsp_status,
   output ram_req_type      ram_req,
   input  word_type         rd_data
);

   state_type             state_ff, state_in;
   logic [WORD_CNT_W-1:0] iss_ff, iss_in;
   logic                  chkv_ff, chkv_in;
   word_idx_type          chk_ff, chk_in;
   logic [BLK_W-1:0]      blk_ff, blk_in;
   logic [BLK_W-1:0]      res_blk_ff, res_blk_in;
   logic [1:0]            res_st_ff, res_st_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [BLK_W-1:0]      rsp_blk_ff, rsp_blk_in;
   logic [1:0]            rsp_st_ff, rsp_st_in;

   logic [CNT_W-1:0]      n_cnt;
   logic [CNT_W-1:0]      n_sum;
   logic [WORD_CNT_W-1:0] n_words;
   word_type              free_bits;
   logic                  hit;
   bit_idx_type           hit_idx;
   logic                  last_word;
   logic                  blk_set;
   logic                  req_xfer;
   logic                  out_load;
   logic                  free_range;

   always_comb begin
      n_cnt      = (total_blocks > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : total_blocks;
      n_sum      = n_cnt + CNT_W'(WORD_BITS - 1);
      n_words    = n_sum[CNT_W-1:BIT_IDX_W];
      free_bits  = ~rd_data & word_mask(chk_ff, n_cnt);
      hit        = |free_bits;
      hit_idx    = first_one(free_bits);
      last_word  = (WORD_CNT_W'(chk_ff) + WORD_CNT_W'(1)) >= n_words;
      blk_set    = rd_data[blk_ff[BIT_IDX_W-1:0]];
      req_xfer   = req_valid && (state_ff == ST_IDLE);
      out_load   = (state_ff == ST_DELIVER) && (!rsp_valid_ff || rsp_ready);
      free_range = CNT_W'(req_block_no) >= n_cnt;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_action == ACT_ALLOC) begin
                  state_in = (n_words == '0) ? ST_DELIVER : ST_ALLOC;
               end else begin
                  state_in = free_range ? ST_DELIVER : ST_FREE_CHK;
               end
            end
         end
         ST_ALLOC: begin
            if (chkv_ff && (hit || last_word)) begin
               state_in = ST_DELIVER;
            end
         end
         ST_FREE_CHK: state_in = ST_DELIVER;
         ST_DELIVER: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready       = 1'b0;
      iss_in          = iss_ff;
      chkv_in         = chkv_ff;
      chk_in          = chk_ff;
      blk_in          = blk_ff;
      res_blk_in      = res_blk_ff;
      res_st_in       = res_st_ff;
      ram_req         = '0;
      ram_req.wr_addr = chk_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_blk_in      = rsp_blk_ff;
      rsp_st_in       = rsp_st_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready       = 1'b1;
            ram_req.rd_addr = req_block_no[BLK_W-1:BIT_IDX_W];
            if (req_xfer) begin
               blk_in  = req_block_no;
               iss_in  = '0;
               chkv_in = 1'b0;
               if (req_action == ACT_ALLOC) begin
                  res_blk_in = '0;
                  res_st_in  = STAT_FULL;
               end else begin
                  res_blk_in = req_block_no;
                  res_st_in  = STAT_RANGE;
               end
            end
         end
         ST_ALLOC: begin
            ram_req.rd_addr = iss_ff[WORD_IDX_W-1:0];
            chkv_in         = iss_ff < n_words;
            chk_in          = iss_ff[WORD_IDX_W-1:0];
            if (iss_ff < n_words) begin
               iss_in = iss_ff + WORD_CNT_W'(1);
            end
            if (chkv_ff && hit) begin
               ram_req.wr_en   = 1'b1;
               ram_req.wr_addr = chk_ff;
               ram_req.wr_data = rd_data | (word_type'(1) << hit_idx);
               res_blk_in      = {chk_ff, hit_idx};
               res_st_in       = STAT_OK;
            end else if (chkv_ff && last_word) begin
               res_blk_in = '0;
               res_st_in  = STAT_FULL;
            end
         end
         ST_FREE_CHK: begin
            res_blk_in = blk_ff;
            if (blk_set) begin
               ram_req.wr_en   = 1'b1;
               ram_req.wr_addr = blk_ff[BLK_W-1:BIT_IDX_W];
               ram_req.wr_data = rd_data &
                                 ~(word_type'(1) << blk_ff[BIT_IDX_W-1:0]);
               res_st_in       = STAT_OK;
            end else begin
               res_st_in = STAT_DOUBLE;
            end
         end
         ST_DELIVER: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               rsp_blk_in   = res_blk_ff;
               rsp_st_in    = res_st_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         chkv_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chkv_ff      <= chkv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      iss_ff     <= iss_in;
      chk_ff     <= chk_in;
      blk_ff     <= blk_in;
      res_blk_ff <= res_blk_in;
      res_st_ff  <= res_st_in;
      rsp_blk_ff <= rsp_blk_in;
      rsp_st_ff  <= rsp_st_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_block = rsp_blk_ff;
   assign rsp_status       = rsp_st_ff;

   `BBA_ASSERT_IMP(a_wr_only_in_check, clock, reset, ram_req.wr_en, (state_ff == ST_ALLOC) || (state_ff == ST_FREE_CHK))
   `BBA_ASSERT_NXT(a_xfer_leaves_idle, clock, reset, req_xfer, state_ff != ST_IDLE)
   `BBA_ASSERT_IMP(a_hit_in_range, clock, reset, (state_ff == ST_ALLOC) && chkv_ff && hit, WORD_CNT_W'(chk_ff) < n_words)
   `BBA_ASSERT_NXT(a_load_sets_valid, clock, reset, out_load, rsp_valid_ff)

endmodule

// ===== src/bitmap_block_allocator.sv =====
// Bitmap block allocator, top level.
// Instantiates bba_csr, bba_map_ram and bba_ctrl; uses bba_pkg.
//
// Usage:
//   req channel (req_valid/req_ready): req_action 0 allocates the first free
//   block below the block count, 1 frees req_block_no. Every transfer gives
//   exactly one transfer on the rsp channel with rsp_result_block and
//   rsp_status (ok, no free block, double free, out of range).
//   The block works on one request at a time. An allocate scans one 64-bit
//   map word per cycle out of the map memory, checks each word when its read
//   returns and sets the lowest free bit of the first word that has one; when
//   the last word has none, the result is no free block. A free reads the
//   word, then clears the bit or reports a double free; an out-of-range free
//   or a zero-count allocate goes straight to the result. The next request is
//   taken in the cycle after the result loads; the scan sets the allocate rate.
//   The result sits in an output register; a new request is taken while it
//   waits, and the block holds its next result until the receiver takes it.
//   Reset marks every block free at once (per-word valid bits) and sets the
//   block count to 4096; requests are taken in the first cycle after reset.
//   The csr port holds total_blocks at byte address 0; write it only while idle.
module bitmap_block_allocator
   import bba_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_action,
   input  logic [BLK_W-1:0]      req_block_no,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [BLK_W-1:0]      rsp_result_block,
   output logic [1:0]            rsp_status,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [CNT_W-1:0] total_blocks;
   ram_req_type      ram_req;
   word_type         rd_data;

   bba_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .total_blocks (total_blocks)
   );

   bba_map_ram u_map_ram (
      .clock   (clock),
      .reset   (reset),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   bba_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .total_blocks     (total_blocks),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_block_no     (req_block_no),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_block (rsp_result_block),
      .rsp_status       (rsp_status),
      .ram_req          (ram_req),
      .rd_data          (rd_data)
   );

endmodule
